/* design/bfa_pkg.sv */
package bfa_pkg;

    localparam int FRAME_SHIFT = 12;

    typedef enum logic [1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_FREE   = 2'd1,
        MODE_UNMARK = 2'd2,
        MODE_MARK   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NO_ROOM = 2'd1,
        ST_ZERO    = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request, reset scan
        logic scan_step;  // examine word at scan pointer
        logic rng_init;   // set range pointer to chosen start
        logic rng_step;   // apply one word of the range
        logic finish;     // drive result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic zero_cnt;
        logic is_alloc;
        logic scan_found;
        logic scan_end;
        logic rng_done;
    } t_sts;

endpackage

/* design/bfa_ctrl.sv */
module bfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output bfa_pkg::t_cmd o_cmd,
    input  bfa_pkg::t_sts i_sts
);
    import bfa_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DEC   = 6'b000010,
        S_SCAN  = 6'b000100,
        S_RINIT = 6'b001000,
        S_RNG   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.zero_cnt)      n_state = S_DONE;
                else if (i_sts.is_alloc) n_state = S_SCAN;
                else                     n_state = S_RINIT;
            end
            S_SCAN: begin
                // found checked on the state before each step
                if (i_sts.scan_found)    n_state = S_RINIT;
                else if (i_sts.scan_end) n_state = S_DONE;
                else                     o_cmd.scan_step = 1'b1;
            end
            S_RINIT: begin
                o_cmd.rng_init = 1'b1;
                n_state        = S_RNG;
            end
            S_RNG: begin
                if (i_sts.rng_done) n_state = S_DONE;
                else                o_cmd.rng_step = 1'b1;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* design/bfa_dp.sv */
module bfa_dp #(
    parameter int MAX_FRAMES = 4096,
    parameter int WORD_BITS  = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bfa_pkg::t_cmd i_cmd,
    output bfa_pkg::t_sts o_sts,
    input  logic [1:0]    i_mode,
    input  logic [31:0]   i_address,
    input  logic [12:0]   i_count,
    input  logic [31:0]   i_region_length,
    input  logic [12:0]   i_frame_limit,
    output logic          o_done,
    output logic [1:0]    o_status,
    output logic [31:0]   o_run_address,
    output logic [12:0]   o_used_frames
);
    import bfa_pkg::*;

    localparam int WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = $clog2(WORD_BITS);
    localparam int FW    = $clog2(MAX_FRAMES) + 1;
    localparam int CW    = $clog2(MAX_FRAMES + 1) + 1;
    localparam int PW    = FW + 21;               // frame arithmetic headroom

    // word-serial bit map; per-word valid bits give the reset image
    logic [WORD_BITS-1:0] r_map [WORDS];
    logic [WORDS-1:0]     r_wvld;
    logic [CW-1:0]        r_used;

    logic [1:0]    r_mode;
    logic [PW-1:0] r_first, r_end;
    logic [12:0]   r_cnt;
    logic [FW-1:0] r_limit;
    logic [FW-1:0] r_f;            // scan frame pointer (word aligned)
    logic [12:0]   r_run;
    logic          r_found;
    logic [FW-1:0] r_start;
    logic [PW-1:0] r_rp;           // range pointer, word aligned
    logic [1:0]    r_status;
    logic [31:0]   r_addr;
    logic          r_done;

    logic [WORD_BITS-1:0] r_rdata;  // registered read port
    logic                 r_rvld;
    logic                 r_rzero;

    logic [WORD_BITS-1:0] w_word;
    logic [WW-1:0]        w_widx;
    logic [WW-1:0]        w_ridx;
    logic [FW-1:0]        w_nf;
    logic [PW-1:0]        w_nrp;

    always_comb begin
        w_nf = r_f;
        if (i_cmd.load)           w_nf = '0;
        else if (i_cmd.scan_step) w_nf = r_f + FW'(WORD_BITS);
        w_nrp = r_rp;
        if (i_cmd.rng_init) begin
            if (r_mode == MODE_ALLOC) w_nrp = PW'(r_start) & ~PW'(WORD_BITS - 1);
            else                      w_nrp = r_first & ~PW'(WORD_BITS - 1);
        end else if (i_cmd.rng_step) begin
            w_nrp = r_rp + PW'(WORD_BITS);
        end
        // read ahead the word that the next cycle works on
        if (i_cmd.rng_init || i_cmd.rng_step) w_ridx = w_nrp[BW +: WW];
        else                                  w_ridx = w_nf[BW +: WW];
        w_widx = r_rp[BW +: WW];
        w_word = r_rvld ? r_rdata : (r_rzero ? WORD_BITS'(1) : '0);
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_map[w_ridx];
        r_rvld  <= r_wvld[w_ridx];
        r_rzero <= (w_ridx == '0);
        if (i_cmd.rng_step) r_map[w_widx] <= g_word;
    end

    // scan: free run ending at each bit, found in parallel across the word
    logic [12:0]   s_run;
    logic          s_hit;
    logic [FW-1:0] s_start;
    always_comb begin
        logic [FW-1:0] fr;
        logic [12:0]   run_b;
        logic [BW:0]   last_u;         // one above the last used bit, 0 if none
        s_hit   = 1'b0;
        s_start = '0;
        last_u  = '0;
        run_b   = r_run;
        for (int b = 0; b < WORD_BITS; b++) begin
            fr = r_f + FW'(b);
            if (w_word[b]) last_u = (BW+1)'(b + 1);
            if (w_word[b])         run_b = '0;
            else if (last_u == '0) run_b = r_run + 13'(b + 1);
            else                   run_b = 13'(b + 1) - 13'(last_u);
            if (!s_hit && fr < r_limit && !w_word[b] && run_b == r_cnt) begin
                s_hit   = 1'b1;
                s_start = fr + FW'(1) - FW'(r_cnt);
            end
        end
        s_run = run_b;
    end

    // range: new word and flipped-bit count
    logic [WORD_BITS-1:0] g_word;
    logic [BW:0]          g_flip;
    logic                 g_mark;
    always_comb begin
        logic [PW-1:0] fr;
        g_mark = (r_mode == MODE_ALLOC) || (r_mode == MODE_MARK);
        g_word = w_word;
        g_flip = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            fr = r_rp + PW'(b);
            if (fr >= r_first && fr < r_end && !(fr == '0 && !g_mark)) begin
                if (w_word[b] != g_mark) begin
                    g_word[b] = g_mark;
                    g_flip    = g_flip + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvld <= '0;
            r_used <= CW'(1);
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.rng_step) begin
                r_wvld[w_widx] <= 1'b1;
                if (g_mark) r_used <= r_used + CW'(g_flip);
                else        r_used <= r_used - CW'(g_flip);
            end
        end
    end

    logic [PW-1:0] w_n;
    assign w_n = (i_mode[1]) ? PW'(i_region_length[31:FRAME_SHIFT]) : PW'(i_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_cnt    <= i_count;
            r_first  <= PW'(i_address[31:FRAME_SHIFT]);
            r_end    <= (PW'(i_address[31:FRAME_SHIFT]) + w_n > PW'(MAX_FRAMES))
                        ? PW'(MAX_FRAMES) : PW'(i_address[31:FRAME_SHIFT]) + w_n;
            r_limit  <= (i_frame_limit > 13'(MAX_FRAMES > 8191 ? 8191 : MAX_FRAMES))
                        ? FW'(MAX_FRAMES) : FW'(i_frame_limit);
            r_f      <= '0;
            r_run    <= '0;
            r_found  <= 1'b0;
            r_status <= ST_DONE;
            r_addr   <= '0;
        end
        if (i_cmd.scan_step) begin
            r_f   <= r_f + FW'(WORD_BITS);
            r_run <= s_run;
            if (s_hit) begin
                r_found <= 1'b1;
                r_start <= s_start;
            end
        end
        if (o_sts.zero_cnt && !i_cmd.load) r_status <= ST_ZERO;
        if (o_sts.is_alloc && o_sts.scan_end && !r_found && !o_sts.zero_cnt &&
            !i_cmd.scan_step && !i_cmd.load)
            r_status <= ST_NO_ROOM;
        if (i_cmd.rng_init) begin
            if (r_mode == MODE_ALLOC) begin
                r_first <= PW'(r_start);
                r_end   <= PW'(r_start) + PW'(r_cnt);
                r_rp    <= PW'(r_start) & ~PW'(WORD_BITS - 1);
                r_addr  <= 32'(r_start) << FRAME_SHIFT;
            end else begin
                r_rp    <= r_first & ~PW'(WORD_BITS - 1);
            end
        end
        if (i_cmd.rng_step) r_rp <= r_rp + PW'(WORD_BITS);
    end

    always_comb begin
        o_sts.zero_cnt   = (r_mode[1] == 1'b0) && (r_cnt == '0);
        o_sts.is_alloc   = (r_mode == MODE_ALLOC);
        o_sts.scan_found = r_found;
        o_sts.scan_end   = (r_f >= r_limit);
        o_sts.rng_done   = (r_rp >= r_end);
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_run_address = r_addr;
    assign o_used_frames = 13'(r_used);

endmodule

/* design/bitmap_frame_allocator.sv */
// First-fit bitmap page-frame allocator. One request is taken when start is
// high and busy low; exactly one result follows as a single-cycle o_done
// pulse in the first cycle with busy low, and the receiver cannot stall it.
// The bit map is a word-wide memory with a registered read, walked one word
// (WORD_BITS frames) per cycle. A successful allocation decodes the request,
// scans words up to the one holding the end of the run (at most
// frame_count/WORD_BITS rounded up), sets up the range and writes the words
// the run touches; a refused allocation stops after the scan and a zero
// count after decoding. Free, unmark and mark requests decode, set up the
// range and write the words it touches inside the map. Frame count writes
// are always accepted. No clearing pass after reset.
module bitmap_frame_allocator #(
    parameter int MAX_FRAMES = 4096,
    parameter int WORD_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_address,
    input  logic [12:0] i_count,
    input  logic [31:0] i_region_length,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_frame_count,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [31:0] o_run_address,
    output logic [12:0] o_used_frames
);
    import bfa_pkg::*;

    t_cmd        w_cmd;
    t_sts        w_sts;
    logic [12:0] r_frame_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)         r_frame_count <= 13'd4096;
        else if (i_cfg_valid) r_frame_count <= i_cfg_frame_count;
    end

    bfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    bfa_dp #(.MAX_FRAMES(MAX_FRAMES), .WORD_BITS(WORD_BITS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_mode          (i_mode),
        .i_address       (i_address),
        .i_count         (i_count),
        .i_region_length (i_region_length),
        .i_frame_limit   (r_frame_count),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_run_address   (o_run_address),
        .o_used_frames   (o_used_frames)
    );

endmodule
